// ----- sv/pcg_pkg.sv -----
// shared types, codes, microcode table and helpers for the pcg32 generator
package pcg_pkg;

   localparam int unsigned ValueWidth  = 32;
   localparam int unsigned StateWidth  = 64;
   localparam int unsigned StreamWidth = 63;
   localparam int unsigned PcWidth     = 5;
   localparam int unsigned CntWidth    = 5;

   localparam logic [31:0] MultLo = 32'h4C957F2D;
   localparam logic [31:0] MultHi = 32'h5851F42D;

   localparam logic [1:0] CMD_RESEED = 2'd0;
   localparam logic [1:0] CMD_NEXT   = 2'd1;
   localparam logic [1:0] CMD_RANGE  = 2'd2;
   localparam logic [1:0] CMD_NONE   = 2'd3;

   localparam logic CSR_SEED   = 1'b0;
   localparam logic CSR_STREAM = 1'b1;

   localparam logic [1:0] MUL_NONE = 2'd0;
   localparam logic [1:0] MUL_LL   = 2'd1;
   localparam logic [1:0] MUL_LH   = 2'd2;
   localparam logic [1:0] MUL_HL   = 2'd3;

   localparam logic [1:0] ACC_HOLD  = 2'd0;
   localparam logic [1:0] ACC_LOAD  = 2'd1;
   localparam logic [1:0] ACC_ADDHI = 2'd2;

   localparam logic [1:0] ST_HOLD     = 2'd0;
   localparam logic [1:0] ST_ZERO_INC = 2'd1;
   localparam logic [1:0] ST_ACC_INC  = 2'd2;
   localparam logic [1:0] ST_ADD_SEED = 2'd3;

   localparam logic [1:0] VAL_HOLD = 2'd0;
   localparam logic [1:0] VAL_ZERO = 2'd1;
   localparam logic [1:0] VAL_PERM = 2'd2;
   localparam logic [1:0] VAL_REM  = 2'd3;

   localparam logic [1:0] DIV_NONE = 2'd0;
   localparam logic [1:0] DIV_INIT = 2'd1;
   localparam logic [1:0] DIV_STEP = 2'd2;

   localparam logic [1:0] JMP_NEXT  = 2'd0;
   localparam logic [1:0] JMP_RANGE = 2'd1;
   localparam logic [1:0] JMP_LOOP  = 2'd2;
   localparam logic [1:0] JMP_END   = 2'd3;

   localparam logic [PcWidth-1:0] PC_RESEED = 5'd0;
   localparam logic [PcWidth-1:0] PC_DRAW   = 5'd12;
   localparam logic [PcWidth-1:0] PC_NONE   = 5'd19;
   localparam logic [PcWidth-1:0] PC_LAST   = 5'd19;

   typedef logic [ValueWidth-1:0] value_type;
   typedef logic [StateWidth-1:0] state_type;

   typedef struct packed {
      logic [1:0] mul;
      logic [1:0] acc;
      logic [1:0] st;
      logic [1:0] val;
      logic [1:0] div;
      logic [1:0] jmp;
   } ucode_type;

   function automatic ucode_type ucode(input logic [PcWidth-1:0] pc);
      ucode_type cw;
      cw = '{MUL_NONE, ACC_HOLD, ST_HOLD, VAL_HOLD, DIV_NONE, JMP_NEXT};
      case (pc)
         5'd0:  cw.st = ST_ZERO_INC;
         5'd1:  cw.mul = MUL_LL;
         5'd2:  begin cw.mul = MUL_LH; cw.acc = ACC_LOAD; end
         5'd3:  begin cw.mul = MUL_HL; cw.acc = ACC_ADDHI; end
         5'd4:  cw.acc = ACC_ADDHI;
         5'd5:  cw.st = ST_ACC_INC;
         5'd6:  cw.st = ST_ADD_SEED;
         5'd7:  cw.mul = MUL_LL;
         5'd8:  begin cw.mul = MUL_LH; cw.acc = ACC_LOAD; end
         5'd9:  begin cw.mul = MUL_HL; cw.acc = ACC_ADDHI; end
         5'd10: cw.acc = ACC_ADDHI;
         5'd11: begin cw.st = ST_ACC_INC; cw.val = VAL_ZERO; cw.jmp = JMP_END; end
         5'd12: begin cw.mul = MUL_LL; cw.val = VAL_PERM; end
         5'd13: begin cw.mul = MUL_LH; cw.acc = ACC_LOAD; end
         5'd14: begin cw.mul = MUL_HL; cw.acc = ACC_ADDHI; end
         5'd15: cw.acc = ACC_ADDHI;
         5'd16: begin cw.st = ST_ACC_INC; cw.div = DIV_INIT; cw.jmp = JMP_RANGE; end
         5'd17: begin cw.div = DIV_STEP; cw.jmp = JMP_LOOP; end
         5'd18: begin cw.val = VAL_REM; cw.jmp = JMP_END; end
         5'd19: begin cw.val = VAL_ZERO; cw.jmp = JMP_END; end
         default: cw.jmp = JMP_END;
      endcase
      return cw;
   endfunction

   function automatic logic [PcWidth-1:0] entry(input logic [1:0] cmd);
      logic [PcWidth-1:0] pc;
      case (cmd)
         CMD_RESEED: pc = PC_RESEED;
         CMD_NEXT:   pc = PC_DRAW;
         CMD_RANGE:  pc = PC_DRAW;
         default:    pc = PC_NONE;
      endcase
      return pc;
   endfunction

   // xsh-rr output permutation of a state
   function automatic value_type permute(input state_type s);
      value_type         x;
      logic [4:0]        r;
      logic [63:0]       xx;
      x  = ValueWidth'(((s >> 18) ^ s) >> 27);
      r  = s[63:59];
      xx = {x, x} >> r;
      return xx[31:0];
   endfunction

endpackage

// ----- sv/pcg_ifs.sv -----
// request and response channel interfaces for the pcg32 generator
interface pcg_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] command;
   logic [31:0] bound;
   modport source (output valid, output command, output bound, input ready);
   modport sink (input valid, input command, input bound, output ready);
endinterface

interface pcg_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] value;
   modport source (output valid, output value, input ready);
   modport sink (input valid, input value, output ready);
endinterface

// ----- sv/pcg32_generator_with_range.sv -----
// pcg32 xsh-rr generator with range reduction, run by a microcoded sequencer
// range with an all-ones bound finishes at the same step as next; other bounds add 32 remainder steps
// the next item is accepted the cycle after the result is loaded into the output register
// the advance uses one 32x32 multiplier three times over five microcode steps
// synchronous reset: state 0, increment 1, both csr registers 0, channels empty
module pcg32_generator_with_range (
   input  logic             clock,
   input  logic             reset,
   pcg_req_if.sink          req_ch,
   pcg_rsp_if.source        rsp_ch,
   input  logic             csr_write_enable,
   input  logic             csr_index,
   input  logic [63:0]      csr_write_data
);

   logic                            busy_ff, busy_in;
   logic [pcg_pkg::PcWidth-1:0]     pc_ff, pc_in;
   logic [pcg_pkg::CntWidth-1:0]    cnt_ff, cnt_in;
   logic [1:0]                      cmd_ff;
   logic [31:0]                     bound_ff;
   pcg_pkg::state_type              state_ff, state_in;
   pcg_pkg::state_type              inc_ff, inc_in;
   pcg_pkg::state_type              seed_ff;
   logic [pcg_pkg::StreamWidth-1:0] stream_ff;
   pcg_pkg::state_type              acc_ff, acc_in;
   logic [63:0]                     prod_ff, prod_in;
   pcg_pkg::value_type              val_ff, val_in;
   pcg_pkg::value_type              rem_ff, rem_in;
   pcg_pkg::value_type              div_ff, div_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   pcg_pkg::value_type              rsp_value_ff;

   pcg_pkg::ucode_type              cw;
   logic                            accept;
   logic                            range_go;
   logic                            finish;
   logic                            stall;
   logic                            go;
   logic [31:0]                     mul_a, mul_b;
   logic [32:0]                     trial;
   logic [32:0]                     trial_diff;

   assign cw       = pcg_pkg::ucode(pc_ff);
   assign accept   = req_ch.valid && req_ch.ready;
   assign range_go = (cmd_ff == pcg_pkg::CMD_RANGE) && (bound_ff != '1);
   assign finish   = (cw.jmp == pcg_pkg::JMP_END) ||
                     ((cw.jmp == pcg_pkg::JMP_RANGE) && !range_go);
   assign stall    = finish && rsp_valid_ff && !rsp_ch.ready;
   assign go       = busy_ff && !stall;

   assign req_ch.ready = !busy_ff;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.value = rsp_value_ff;

   always_comb begin
      case (cw.mul)
         pcg_pkg::MUL_LH: begin mul_a = state_ff[31:0];  mul_b = pcg_pkg::MultHi; end
         pcg_pkg::MUL_HL: begin mul_a = state_ff[63:32]; mul_b = pcg_pkg::MultLo; end
         default:         begin mul_a = state_ff[31:0];  mul_b = pcg_pkg::MultLo; end
      endcase
      prod_in = 64'(mul_a) * 64'(mul_b);
   end

   assign trial      = {rem_ff, val_ff[31]};
   assign trial_diff = trial - {1'b0, div_ff};

   always_comb begin
      busy_in      = busy_ff;
      pc_in        = pc_ff;
      cnt_in       = cnt_ff;
      state_in     = state_ff;
      inc_in       = inc_ff;
      acc_in       = acc_ff;
      val_in       = val_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;

      if (accept) begin
         busy_in = 1'b1;
         pc_in   = pcg_pkg::entry(req_ch.command);
      end

      if (go) begin
         case (cw.acc)
            pcg_pkg::ACC_LOAD:  acc_in = prod_ff;
            pcg_pkg::ACC_ADDHI: acc_in = acc_ff + {prod_ff[31:0], 32'd0};
            default:            acc_in = acc_ff;
         endcase

         case (cw.st)
            pcg_pkg::ST_ZERO_INC: begin
               state_in = '0;
               inc_in   = {stream_ff, 1'b1};
            end
            pcg_pkg::ST_ACC_INC:  state_in = acc_ff + inc_ff;
            pcg_pkg::ST_ADD_SEED: state_in = state_ff + seed_ff;
            default:              state_in = state_ff;
         endcase

         case (cw.div)
            pcg_pkg::DIV_INIT: begin
               rem_in = '0;
               div_in = bound_ff + 32'd1;
               cnt_in = '1;
            end
            pcg_pkg::DIV_STEP: begin
               rem_in = trial_diff[32] ? trial[31:0] : trial_diff[31:0];
               val_in = {val_ff[30:0], 1'b0};
            end
            default: rem_in = rem_ff;
         endcase

         case (cw.val)
            pcg_pkg::VAL_ZERO: val_in = '0;
            pcg_pkg::VAL_PERM: val_in = pcg_pkg::permute(state_ff);
            pcg_pkg::VAL_REM:  val_in = rem_ff;
            default:           val_in = val_in;
         endcase

         if (finish) begin
            busy_in      = 1'b0;
            rsp_valid_in = 1'b1;
         end else if ((cw.jmp == pcg_pkg::JMP_LOOP) && (cnt_ff != '0)) begin
            cnt_in = cnt_ff - 1'b1;
         end else begin
            pc_in = pc_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pc_ff        <= '0;
         cnt_ff       <= '0;
         state_ff     <= '0;
         inc_ff       <= 64'd1;
         seed_ff      <= '0;
         stream_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         pc_ff        <= pc_in;
         cnt_ff       <= cnt_in;
         state_ff     <= state_in;
         inc_ff       <= inc_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable && (csr_index == pcg_pkg::CSR_SEED)) begin
            seed_ff <= csr_write_data;
         end
         if (csr_write_enable && (csr_index == pcg_pkg::CSR_STREAM)) begin
            stream_ff <= csr_write_data[pcg_pkg::StreamWidth-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= req_ch.command;
         bound_ff <= req_ch.bound;
      end
      if (go && (cw.mul != pcg_pkg::MUL_NONE)) begin
         prod_ff <= prod_in;
      end
      if (go && finish) begin
         rsp_value_ff <= val_in;
      end
      acc_ff <= acc_in;
      val_ff <= val_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   a_inc_odd: assert property (@(posedge clock) disable iff (reset) inc_ff[0])
      else $error("increment lost its low bit");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy_ff)
      else $error("sequencer not busy after accepting an item");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && stall) |=> ($stable(pc_ff) && $stable(state_ff) && busy_ff))
      else $error("sequencer moved while the result was blocked");

   a_rem_below: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && (cw.div == pcg_pkg::DIV_STEP)) |-> (rem_ff < div_ff))
      else $error("partial remainder not below divisor");

   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (pc_ff <= pcg_pkg::PC_LAST))
      else $error("step counter beyond the program");

endmodule
